// ----- rtl/pidbw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidbw_pkg
// Widths, register indexes, reset values and saturation helper shared by
// the band-limited PID controller.
// ----------------------------------------------------------------------------
package pidbw_pkg;

  localparam int unsigned DataW   = 32;  // signed Q16.16 sample width
  localparam int unsigned GainW   = 31;  // unsigned gain and band width
  localparam int unsigned ErrW    = 33;  // difference of two samples
  localparam int unsigned AccW    = 36;  // headroom for sums of terms
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned FracW   = 16;

  typedef logic signed [DataW-1:0] q_t;
  typedef logic        [GainW-1:0] gain_t;
  typedef logic signed [ErrW-1:0]  err_t;
  typedef logic signed [AccW-1:0]  acc_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegPropBand = 3'd0,
    RegPGain    = 3'd1,
    RegIGain    = 3'd2,
    RegDGain    = 3'd3,
    RegFfGain   = 3'd4,
    RegOutMin   = 3'd5,
    RegOutMax   = 3'd6
  } cfg_reg_e;

  localparam q_t QMax      = 32'sh7FFF_FFFF;
  localparam q_t QMin      = -32'sh8000_0000;
  localparam q_t OutMinRst = -32'sd65536;
  localparam q_t OutMaxRst = 32'sd65536;

  // Saturate a wide signed sum to the Q16.16 range.
  function automatic q_t sat_q(acc_t v);
    q_t r;
    if (v > acc_t'(QMax)) begin
      r = QMax;
    end else if (v < acc_t'(QMin)) begin
      r = QMin;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/pidbw_qmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidbw_qmul
// Q16.16 multiply: exact product, floor shift by the fraction width,
// saturation to 32 bits.
// ----------------------------------------------------------------------------
module pidbw_qmul (
  input  pidbw_pkg::err_t a_i,
  input  pidbw_pkg::q_t   b_i,
  output pidbw_pkg::q_t   p_o
);
  import pidbw_pkg::*;

  localparam int unsigned ProdW = ErrW + DataW;

  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] shr;

  assign prod = a_i * b_i;
  // arithmetic shift of a signed value rounds toward minus infinity
  assign shr  = prod >>> FracW;

  always_comb begin
    if (shr > ProdW'(QMax)) begin
      p_o = QMax;
    end else if (shr < ProdW'(QMin)) begin
      p_o = QMin;
    end else begin
      p_o = shr[DataW-1:0];
    end
  end

endmodule

// ----- rtl/pid_controller_band_antiwindup_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_band_antiwindup_unit
// PID controller with proportional band, anti-windup integral and
// feedforward, signed Q16.16.
// ----------------------------------------------------------------------------
// One sample transaction per clock is taken while in_stall_o is low, and one
// result transaction is returned per sample, in order; throughput is one per
// cycle while out_stall_i is low. The four Q16.16 multiplies sit in the second
// stage; the integral recursion (add, saturate, anti-windup limit, final sum
// and clamp) is closed in the last stage, right where the output register is
// loaded, so that the next sample sees the updated integral without a gap.
// Each stage holds its contents while the one after it is full and held, so
// the input keeps being taken while a finished result waits under out_stall_i,
// until all stages are full. Configuration takes effect for samples accepted
// after the write; write only while idle.
// ----------------------------------------------------------------------------
module pid_controller_band_antiwindup_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // sample channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pidbw_pkg::q_t                  measured_i,
  input  pidbw_pkg::q_t                  target_i,
  input  logic                           clear_integral_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pidbw_pkg::q_t                  drive_o,
  output pidbw_pkg::q_t                  ff_term_o,
  output pidbw_pkg::q_t                  p_term_o,
  output pidbw_pkg::q_t                  i_term_o,
  output pidbw_pkg::q_t                  d_term_o,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [pidbw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pidbw_pkg::DataW-1:0]    cfg_wdata_i
);
  import pidbw_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  gain_t prop_band_q, p_gain_q, i_gain_q, d_gain_q;
  q_t    ff_gain_q, out_min_q, out_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_band_q <= '0;
      p_gain_q    <= '0;
      i_gain_q    <= '0;
      d_gain_q    <= '0;
      ff_gain_q   <= '0;
      out_min_q   <= OutMinRst;
      out_max_q   <= OutMaxRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegPropBand: prop_band_q <= cfg_wdata_i[GainW-1:0];
        RegPGain:    p_gain_q    <= cfg_wdata_i[GainW-1:0];
        RegIGain:    i_gain_q    <= cfg_wdata_i[GainW-1:0];
        RegDGain:    d_gain_q    <= cfg_wdata_i[GainW-1:0];
        RegFfGain:   ff_gain_q   <= q_t'(cfg_wdata_i);
        RegOutMin:   out_min_q   <= q_t'(cfg_wdata_i);
        RegOutMax:   out_max_q   <= q_t'(cfg_wdata_i);
        default:     ;  // unused index, ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake: a stage loads when it is empty or moves on itself
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, out_v_q;
  logic rdy1, rdy2, rdy3, rdy_out;
  logic in_acc;

  assign rdy_out    = !out_v_q || !out_stall_i;
  assign rdy3       = !v3_q || rdy_out;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;
  assign in_acc     = in_valid_i && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy1)    v1_q    <= in_valid_i;
      if (rdy2)    v2_q    <= v1_q;
      if (rdy3)    v3_q    <= v2_q;
      if (rdy_out) out_v_q <= v3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input register, measurement delta, integral enable
  // --------------------------------------------------------------------------
  q_t   prev_meas_q;
  logic pend_clr_q;
  q_t   meas1_q, tgt1_q;
  err_t diff1_q;
  logic ien1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_meas_q <= '0;
      pend_clr_q  <= 1'b1;  // first sample starts with a cleared integral
    end else if (in_acc) begin
      prev_meas_q <= measured_i;
      pend_clr_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      meas1_q <= measured_i;
      tgt1_q  <= target_i;
      diff1_q <= err_t'(prev_meas_q) - err_t'(measured_i);
      ien1_q  <= (i_gain_q != '0) && !clear_integral_i && !pend_clr_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: error, band clamp, the four products
  // --------------------------------------------------------------------------
  err_t err, err_c, band;
  logic band_on, in_range;
  q_t   ff_m, p_m, i_m, d_m;

  assign band    = err_t'({1'b0, prop_band_q});
  assign band_on = (prop_band_q != '0);
  assign err     = err_t'(tgt1_q) - err_t'(meas1_q);

  always_comb begin
    err_c    = err;
    in_range = 1'b1;
    if (band_on && (err > band)) begin
      err_c    = band;
      in_range = 1'b0;
    end else if (band_on && (err < -band)) begin
      err_c    = -band;
      in_range = 1'b0;
    end
  end

  pidbw_qmul u_mul_ff (.a_i(err_t'(tgt1_q)), .b_i(ff_gain_q),           .p_o(ff_m));
  pidbw_qmul u_mul_p  (.a_i(err_c),          .b_i(q_t'({1'b0, p_gain_q})), .p_o(p_m));
  pidbw_qmul u_mul_i  (.a_i(err_c),          .b_i(q_t'({1'b0, i_gain_q})), .p_o(i_m));
  pidbw_qmul u_mul_d  (.a_i(diff1_q),        .b_i(q_t'({1'b0, d_gain_q})), .p_o(d_m));

  q_t   ff2_q, p2_q, ip2_q, d2_q;
  logic ien2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      ff2_q  <= ff_m;
      p2_q   <= band_on ? p_m : '0;             // no band: P reported as zero
      ip2_q  <= i_m;
      d2_q   <= ((d_gain_q != '0) && in_range) ? d_m : '0;
      ien2_q <= ien1_q && in_range;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: partial sum and the headroom left for the integral
  // --------------------------------------------------------------------------
  logic signed [DataW:0]   acc_fp;
  logic signed [DataW+1:0] hi_room, lo_room;

  assign acc_fp  = (DataW+1)'(ff2_q) + (DataW+1)'(p2_q);
  assign hi_room = (DataW+2)'(out_max_q) - (DataW+2)'(acc_fp);
  assign lo_room = (DataW+2)'(out_min_q) - (DataW+2)'(acc_fp);

  q_t                      ff3_q, p3_q, ip3_q, d3_q;
  logic                    ien3_q;
  logic signed [DataW:0]   acc3_q;
  logic signed [DataW+1:0] hi3_q, lo3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      ff3_q  <= ff2_q;
      p3_q   <= p2_q;
      ip3_q  <= ip2_q;
      d3_q   <= d2_q;
      ien3_q <= ien2_q;
      acc3_q <= acc_fp;
      hi3_q  <= hi_room;
      lo3_q  <= lo_room;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: integral update with anti-windup, total and output clamp
  // --------------------------------------------------------------------------
  q_t   isum_q;
  q_t   s_sat, s_lim, i_new, drive;
  acc_t total;

  always_comb begin
    s_sat = sat_q(acc_t'(isum_q) + acc_t'(ip3_q));
    // integral plus partial sum tested against the limits, upper one first
    if (acc_t'(s_sat) > acc_t'(hi3_q)) begin
      s_lim = sat_q(acc_t'(hi3_q));
    end else if (acc_t'(s_sat) < acc_t'(lo3_q)) begin
      s_lim = sat_q(acc_t'(lo3_q));
    end else begin
      s_lim = s_sat;
    end
    i_new = ien3_q ? s_lim : '0;

    total = acc_t'(acc3_q) + acc_t'(i_new) + acc_t'(d3_q);
    if (total > acc_t'(out_max_q)) begin
      drive = out_max_q;
    end else if (total < acc_t'(out_min_q)) begin
      drive = out_min_q;
    end else begin
      drive = total[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      isum_q <= '0;
    end else if (rdy_out && v3_q) begin
      isum_q <= i_new;
    end
  end

  q_t drive_q, ff_q, p_q, i_q, d_q;

  always_ff @(posedge clk_i) begin
    if (rdy_out && v3_q) begin
      drive_q <= drive;
      ff_q    <= ff3_q;
      p_q     <= p3_q;
      i_q     <= i_new;
      d_q     <= d3_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign drive_o     = drive_q;
  assign ff_term_o   = ff_q;
  assign p_term_o    = p_q;
  assign i_term_o    = i_q;
  assign d_term_o    = d_q;

endmodule

// ----- dv/tb_pid_controller_band_antiwindup_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_controller_band_antiwindup_unit
// Self-checking bench for the band-limited PID controller. A scoreboard class
// tracks its own copy of the register file, integral, last measurement and
// first-sample clear, predicts every result transaction and compares it field
// by field. The bench starts with short directed sequences and then runs
// random register settings with mostly in-band, well-formed samples, random
// idle bursts on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_pid_controller_band_antiwindup_unit;
  import pidbw_pkg::*;

  localparam int          NumPhases   = 15;
  localparam int          PhaseItems  = 108;
  localparam int          PressItems  = 40;
  localparam int          LongHold    = 200;
  localparam int          DrainCycles = 4;    // pipe depth plus margin
  localparam int unsigned CycleLimit  = 400000;
  localparam q_t          One         = 32'sd65536;

  // register setting families
  localparam int CfgDirected = 0;
  localparam int CfgTypical  = 1;
  localparam int CfgNoBand   = 2;
  localparam int CfgExtreme  = 3;
  localparam int CfgInverted = 4;
  localparam int CfgDisabled = 5;
  localparam int CfgRandom   = 6;
  localparam int CfgTight    = 7;

  typedef struct packed {
    q_t drive;
    q_t ff;
    q_t p;
    q_t integ;
    q_t deriv;
  } pid_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts one result per accepted sample, checks in order.
  // --------------------------------------------------------------------------
  class pid_output_scoreboard;
    longint      band, kp, ki, kd, kff, lo_lim, hi_lim;
    longint      integ_acc, last_meas;
    bit          first_clear;
    pid_result_t expected_outputs[$];
    int          mismatches;
    int          checked;

    function new();
      band        = 0;
      kp          = 0;
      ki          = 0;
      kd          = 0;
      kff         = 0;
      lo_lim      = -65536;
      hi_lim      = 65536;
      integ_acc   = 0;
      last_meas   = 0;
      first_clear = 1'b1;
      mismatches  = 0;
      checked     = 0;
    endfunction

    function longint clamp_q32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // exact product, floor shift back to Q16.16, then saturate
    function longint mul_q16(longint a, longint b);
      return clamp_q32((a * b) >>> 16);
    endfunction

    function void write_reg(cfg_reg_e idx, logic [31:0] data);
      case (idx)
        RegPropBand: band   = data[30:0];
        RegPGain:    kp     = data[30:0];
        RegIGain:    ki     = data[30:0];
        RegDGain:    kd     = data[30:0];
        RegFfGain:   kff    = $signed(data);
        RegOutMin:   lo_lim = $signed(data);
        RegOutMax:   hi_lim = $signed(data);
        default: ;
      endcase
    endfunction

    function void note_sample(q_t meas_q, q_t tgt_q, logic clr);
      longint      meas, tgt, err, ff, p, d, sum, s;
      bit          in_band;
      pid_result_t r;
      meas    = meas_q;
      tgt     = tgt_q;
      err     = tgt - meas;
      in_band = 1'b1;
      p       = 0;
      d       = 0;
      ff      = mul_q16(tgt, kff);
      sum     = ff;
      if (band != 0) begin
        if (err > band) begin
          err     = band;
          in_band = 1'b0;
        end else if (err < -band) begin
          err     = -band;
          in_band = 1'b0;
        end
        p   = mul_q16(err, kp);
        sum = sum + p;
      end
      if (ki != 0 && !clr && !first_clear && in_band) begin
        s = clamp_q32(integ_acc + mul_q16(err, ki));
        // anti-windup: upper limit is tested first
        if (s + sum > hi_lim) begin
          s = clamp_q32(hi_lim - sum);
        end else if (s + sum < lo_lim) begin
          s = clamp_q32(lo_lim - sum);
        end
        integ_acc = s;
        sum       = sum + s;
      end else begin
        integ_acc = 0;
      end
      if (kd != 0 && in_band) begin
        d   = mul_q16(last_meas - meas, kd);
        sum = sum + d;
      end
      last_meas   = meas;
      first_clear = 1'b0;
      if (sum > hi_lim) begin
        sum = hi_lim;
      end else if (sum < lo_lim) begin
        sum = lo_lim;
      end
      r.drive = q_t'(sum);
      r.ff    = q_t'(ff);
      r.p     = q_t'(p);
      r.integ = q_t'(integ_acc);
      r.deriv = q_t'(d);
      expected_outputs.push_back(r);
    endfunction

    function void compare_field(string name, q_t exp_v, q_t got_v);
      if (exp_v !== got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_result(q_t drive, q_t ff, q_t p, q_t integ, q_t deriv);
      pid_result_t e;
      if (expected_outputs.size() == 0) begin
        $error("result transaction with no sample outstanding: drive %0d", drive);
        mismatches++;
        return;
      end
      e = expected_outputs.pop_front();
      checked++;
      compare_field("drive", e.drive, drive);
      compare_field("ff_term", e.ff, ff);
      compare_field("p_term", e.p, p);
      compare_field("i_term", e.integ, integ);
      compare_field("d_term", e.deriv, deriv);
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT signals; every input starts at a known value.
  // --------------------------------------------------------------------------
  logic               clk              = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               in_valid_i       = 1'b0;
  logic               in_stall_o;
  q_t                 measured_i       = '0;
  q_t                 target_i         = '0;
  logic               clear_integral_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i      = 1'b0;
  q_t                 drive_o, ff_term_o, p_term_o, i_term_o, d_term_o;
  logic               cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i      = '0;
  logic [DataW-1:0]   cfg_wdata_i      = '0;

  pid_output_scoreboard sb;
  bit          tx_gaps_on    = 1'b1;   // sender may insert idle bursts
  bit          rx_stalls_on  = 1'b1;   // receiver may insert stall bursts
  bit          hold_request  = 1'b0;   // asks the receiver for one long hold-off
  int          samples_sent  = 0;
  int          settings_done = 0;
  int unsigned cycles        = 0;

  always #5 clk = ~clk;

  pid_controller_band_antiwindup_unit uut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .measured_i       (measured_i),
    .target_i         (target_i),
    .clear_integral_i (clear_integral_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .drive_o          (drive_o),
    .ff_term_o        (ff_term_o),
    .p_term_o         (p_term_o),
    .i_term_o         (i_term_o),
    .d_term_o         (d_term_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  // Monitor: samples both channels at the edge; all drivers use NBAs, so the
  // values seen here are the ones the DUT sees. Inputs are noted before the
  // output is checked so ordering holds whatever the pipe depth.
  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_sample(measured_i, target_i, clear_integral_i);
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(drive_o, ff_term_o, p_term_o, i_term_o, d_term_o);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("pid_controller_band_antiwindup_unit verification failed");
      $finish;
    end
  end

  // Receiver: random stall bursts, or one long hold-off counted here while
  // the sender keeps offering, so the pipe fills and stalls its input.
  initial begin
    wait (rst_ni);
    forever begin
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk);
        hold_request = 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // One sample transaction, with an optional idle burst ahead of it. Valid is
  // only lowered for a gap, never dropped and raised in the same step.
  task automatic send_sample(input q_t meas, input q_t tgt, input logic clr);
    int gap;
    gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_i       <= 1'b1;
    measured_i       <= meas;
    target_i         <= tgt;
    clear_integral_i <= clr;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    samples_sent++;
  endtask

  // Mostly samples near the setpoint so the error sits in or just over the
  // band (keeps the integral alive); the rest is full-range noise and
  // extreme values.
  task automatic send_random_sample();
    longint lim, tgt, dev;
    int     pick;
    q_t     meas_v, tgt_v;
    q_t     corner[5];
    corner = '{QMax, QMin, q_t'(0), q_t'(-1), q_t'(1)};
    pick   = $urandom_range(0, 9);
    lim    = (sb.band == 0) ? (4 <<< 16) : sb.band + sb.band / 8 + 1;
    if (lim > (1 <<< 30)) lim = 1 <<< 30;
    if (pick < 7) begin
      tgt    = longint'($urandom_range(0, 16 <<< 16)) - (8 <<< 16);
      dev    = longint'($urandom_range(0, 2 * lim)) - lim;
      tgt_v  = q_t'(tgt);
      meas_v = q_t'(tgt - dev);
    end else if (pick < 9) begin
      tgt_v  = $urandom;
      meas_v = $urandom;
    end else begin
      tgt_v  = corner[$urandom_range(0, 4)];
      meas_v = corner[$urandom_range(0, 4)];
    end
    send_sample(meas_v, tgt_v, $urandom_range(0, 11) == 0);
  endtask

  // Wait until every result is back, then let the pipe settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write all seven registers with a setting of the given family. Band and gain
  // registers get a random bit 31 (not when directed) to check that it is ignored.
  task automatic apply_settings(input int kind);
    logic [31:0] vals[7];
    logic [31:0] lim;
    for (int k = 0; k < 7; k++) vals[k] = $urandom;
    if (kind != CfgRandom && kind != CfgDirected && kind != CfgExtreme) begin
      vals[RegPropBand] = $urandom_range(1 << 14, 8 << 16);
      vals[RegPGain]    = $urandom_range(0, 4 << 16);
      vals[RegIGain]    = $urandom_range(1, 1 << 15);
      vals[RegDGain]    = $urandom_range(0, 1 << 16);
      vals[RegFfGain]   = $urandom_range(0, 4 << 16) - (2 << 16);
      vals[RegOutMin]   = -$urandom_range(1 << 16, 16 << 16);
      vals[RegOutMax]   = $urandom_range(1 << 16, 16 << 16);
    end
    case (kind)
      CfgDirected: begin
        vals[RegPropBand] = 2 << 16;
        vals[RegPGain]    = 3 << 15;
        vals[RegIGain]    = 1 << 14;
        vals[RegDGain]    = 1 << 15;
        vals[RegFfGain]   = 1 << 15;
        vals[RegOutMin]   = -(4 << 16);
        vals[RegOutMax]   = 4 << 16;
      end
      CfgNoBand: vals[RegPropBand] = '0;
      CfgExtreme: begin
        vals[RegPropBand] = 32'h7FFF_FFFF;
        vals[RegPGain]    = 32'h7FFF_FFFF;
        vals[RegIGain]    = 32'h7FFF_FFFF;
        vals[RegDGain]    = 32'h7FFF_FFFF;
        vals[RegFfGain]   = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        vals[RegOutMin]   = 32'h8000_0000;
        vals[RegOutMax]   = 32'h7FFF_FFFF;
      end
      CfgInverted: begin
        lim             = $urandom_range(1 << 16, 4 << 16);
        vals[RegOutMin] = lim;
        vals[RegOutMax] = -lim;
      end
      CfgDisabled: begin
        vals[RegPGain]  = '0;
        vals[RegIGain]  = '0;
        vals[RegDGain]  = '0;
        vals[RegFfGain] = 32'h7FFF_FFFF;
      end
      CfgTight: begin
        vals[RegOutMin] = $urandom_range(0, 2 << 16) - (1 << 16);
        vals[RegOutMax] = vals[RegOutMin];
      end
      default: ;
    endcase
    if (kind != CfgDirected) begin
      for (int k = int'(RegPropBand); k <= int'(RegDGain); k++) begin
        vals[k][31] = $urandom_range(0, 1);
      end
    end
    for (int k = 0; k <= int'(RegOutMax); k++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= cfg_reg_e'(k);
      cfg_wdata_i <= vals[k];
      @(posedge clk);
      sb.write_reg(cfg_reg_e'(k), vals[k]);
    end
    cfg_we_i <= 1'b0;
    settings_done++;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Reset values of the registers: band and gains zero, limits +/-1.0.
    // First sample meets the pending first-sample clear; with ki zero it cannot show.
    send_sample(One, q_t'(0), 1'b0);
    send_sample(-One, One, 1'b0);
    send_sample(QMax, QMin, 1'b1);
    drain();

    // Directed: band 2.0, gains chosen so the integral winds up within a few
    // samples and is then held by the anti-windup limit.
    apply_settings(CfgDirected);
    repeat (9) send_sample(q_t'(0), One, 1'b0);
    send_sample(q_t'(0), 4 * One, 1'b0);       // error over the band
    send_sample(4 * One, q_t'(0), 1'b0);       // error under the band
    send_sample(One / 2, One, 1'b1);           // forced integral clear
    send_sample(One / 2, One, 1'b0);
    send_sample(QMax, QMax, 1'b0);
    send_sample(QMin, QMin, 1'b0);
    send_sample(QMin, QMax, 1'b0);
    send_sample(QMax, QMin, 1'b0);
    send_sample(q_t'(-1), q_t'(-1), 1'b0);
    send_sample(q_t'(0), q_t'(0), 1'b0);
    send_sample(QMax, q_t'(0), 1'b1);
    drain();

    // Random phases over all setting families but the directed one; idling is
    // varied per phase and switched off entirely for the last one.
    for (int ph = 0; ph < NumPhases; ph++) begin
      tx_gaps_on   = (ph % 3 != 2) && (ph != NumPhases - 1);
      rx_stalls_on = (ph % 4 != 3) && (ph != NumPhases - 1);
      apply_settings(1 + ph % 7);
      if (ph == 3) begin
        // back-pressure: long hold-off at the output, sender flat out
        tx_gaps_on   = 1'b0;
        hold_request = 1'b1;
        repeat (PressItems) send_random_sample();
        tx_gaps_on   = 1'b1;
      end
      repeat (PhaseItems) send_random_sample();
      drain();
    end

    $display("Run covered %0d samples and %0d checked results over %0d register settings,",
             samples_sent, sb.checked, settings_done);
    $display("with idle and stall bursts on both channels and a %0d-cycle output hold-off.",
             LongHold);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("pid_controller_band_antiwindup_unit verification clean");
    end else begin
      $display("pid_controller_band_antiwindup_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pidbw_pkg.sv
rtl/pidbw_qmul.sv
rtl/pid_controller_band_antiwindup_unit.sv
dv/tb_pid_controller_band_antiwindup_unit.sv
